FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication that must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication that must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types, codes and the CRC-16 byte update for the Modbus RTU read master.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_TIMEOUT = 2'd2
    } mbrtu_op_t;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS  = 1'b1;
    localparam int unsigned CFG_DATA_W = 8;

    // Reset values of the configuration registers
    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
    localparam logic [2:0] MAX_ATTEMPTS_RESET  = 3'd3;

    // Protocol constants
    localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
    localparam logic [7:0]  BYTE_COUNT_ONE_REG = 8'h02;
    localparam logic [15:0] REG_COUNT_ONE      = 16'h0001;
    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY           = 16'hA001;

    // Positions within the response frame
    localparam logic [2:0] RX_POS_ADDR   = 3'd0;
    localparam logic [2:0] RX_POS_FUNC   = 3'd1;
    localparam logic [2:0] RX_POS_COUNT  = 3'd2;
    localparam logic [2:0] RX_POS_VAL_HI = 3'd3;
    localparam logic [2:0] RX_POS_VAL_LO = 3'd4;
    localparam logic [2:0] RX_POS_CRC_LO = 3'd5;
    localparam logic [2:0] RX_POS_CRC_HI = 3'd6;

    // Positions within the request frame
    localparam logic [2:0] TX_POS_ADDR   = 3'd0;
    localparam logic [2:0] TX_POS_FUNC   = 3'd1;
    localparam logic [2:0] TX_POS_REG_HI = 3'd2;
    localparam logic [2:0] TX_POS_REG_LO = 3'd3;
    localparam logic [2:0] TX_POS_CNT_HI = 3'd4;
    localparam logic [2:0] TX_POS_CNT_LO = 3'd5;
    localparam logic [2:0] TX_POS_CRC_LO = 3'd6;
    localparam logic [2:0] TX_POS_CRC_HI = 3'd7;

    // Command from the transaction control to the result emitter
    typedef struct packed {
        logic        load;
        logic        finish;
        logic        success;
        logic [15:0] value;
        logic [7:0]  slave;
        logic [15:0] register_address;
    } mbrtu_emit_cmd_t;

    // CRC-16/Modbus update by one byte (reflected, LSB first)
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/mbrtu_if.sv
// ----------------------------------------------------------------------------
// mbrtu_in_if / mbrtu_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mbrtu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] register_address;
    logic [7:0]  rx_byte;

    modport source (output valid, output operation, output register_address,
                    output rx_byte, input ready);
    modport sink   (input valid, input operation, input register_address,
                    input rx_byte, output ready);
endinterface

interface mbrtu_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        success;
    logic [15:0] value;

    modport source (output valid, output kind, output tx_byte, output last,
                    output success, output value, input ready);
    modport sink   (input valid, input kind, input tx_byte, input last,
                    input success, input value, output ready);
endinterface

FILE: rtl/mbrtu_emit.sv
// ----------------------------------------------------------------------------
// mbrtu_emit
// Result register: sends a request frame byte by byte with the CRC built
// one byte per transfer, or a single finish result.
// ----------------------------------------------------------------------------
module mbrtu_emit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mbrtu_pkg::mbrtu_emit_cmd_t cmd,
    output logic                      free,
    mbrtu_out_if.source               rsp
);

    logic        valid_reg;
    logic        finish_reg;
    logic        success_reg;
    logic [15:0] value_reg;
    logic [7:0]  slave_reg;
    logic [15:0] register_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;

    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        xfer;

    // Select the frame byte at the current position
    always_comb
    begin
        unique case (idx_reg)
            mbrtu_pkg::TX_POS_ADDR:   cur_byte = slave_reg;
            mbrtu_pkg::TX_POS_FUNC:   cur_byte = mbrtu_pkg::FUNC_READ_HOLDING;
            mbrtu_pkg::TX_POS_REG_HI: cur_byte = register_reg[15:8];
            mbrtu_pkg::TX_POS_REG_LO: cur_byte = register_reg[7:0];
            mbrtu_pkg::TX_POS_CNT_HI: cur_byte = mbrtu_pkg::REG_COUNT_ONE[15:8];
            mbrtu_pkg::TX_POS_CNT_LO: cur_byte = mbrtu_pkg::REG_COUNT_ONE[7:0];
            mbrtu_pkg::TX_POS_CRC_LO: cur_byte = crc_reg[7:0];
            mbrtu_pkg::TX_POS_CRC_HI: cur_byte = crc_reg[15:8];
        endcase
    end

    assign cur_last = finish_reg || (idx_reg == mbrtu_pkg::TX_POS_CRC_HI);
    assign xfer     = valid_reg && rsp.ready;
    assign free     = !valid_reg || (rsp.ready && cur_last);

    // Drive the result fields
    assign rsp.valid   = valid_reg;
    assign rsp.kind    = finish_reg ? mbrtu_pkg::KIND_DONE : mbrtu_pkg::KIND_TX;
    assign rsp.tx_byte = finish_reg ? 8'h00 : cur_byte;
    assign rsp.last    = cur_last;
    assign rsp.success = finish_reg && success_reg;
    assign rsp.value   = (finish_reg && success_reg) ? value_reg : 16'h0000;

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= cmd.load;
        end
    end

    // Load a new command or advance through the frame
    always_ff @(posedge clk)
    begin
        if (free && cmd.load)
        begin
            finish_reg   <= cmd.finish;
            success_reg  <= cmd.success;
            value_reg    <= cmd.value;
            slave_reg    <= cmd.slave;
            register_reg <= cmd.register_address;
            idx_reg      <= mbrtu_pkg::TX_POS_ADDR;
            crc_reg      <= mbrtu_pkg::CRC_INIT;
        end
        else if (xfer && !cur_last)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (idx_reg < mbrtu_pkg::TX_POS_CRC_LO)
            begin
                crc_reg <= mbrtu_pkg::crc_byte(crc_reg, cur_byte);
            end
        end
    end

endmodule

FILE: rtl/modbus_rtu_register_read_master_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_register_read_master_top
// Modbus RTU master that reads one holding register and checks the response.
// ----------------------------------------------------------------------------
// Each input item's state update is done in the cycle the item is taken; a
// start or retry yields eight request bytes (slave address, 0x03, register,
// count 0x0001, CRC low then high) delivered one per cycle from the result
// register while rsp.ready is high; that register builds the CRC one byte per
// transfer; a finish yields one result. Items that cause no result are taken
// every cycle while the result register is free. A new item is taken in the
// cycle the last result of the previous one transfers.
// No clearing pass is needed after reset.
module modbus_rtu_register_read_master_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [mbrtu_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  logic [mbrtu_pkg::CFG_DATA_W-1:0]      wr_data,
    mbrtu_in_if.sink                              req,
    mbrtu_out_if.source                           rsp
);

    `include "assert_macros.svh"

    // Configuration registers
    logic [7:0]  slave_address_reg;
    logic [2:0]  max_attempts_reg;

    // Transaction state
    logic        busy_reg,         busy_next;
    logic [2:0]  attempt_count_reg, attempt_count_next;
    logic [2:0]  rx_count_reg,     rx_count_next;
    logic [15:0] latched_reg,      latched_next;
    logic [15:0] running_crc_reg,  running_crc_next;
    logic        header_good_reg,  header_good_next;
    logic [15:0] value_hold_reg,   value_hold_next;
    logic [7:0]  crc_low_hold_reg, crc_low_hold_next;

    mbrtu_pkg::mbrtu_emit_cmd_t cmd;
    logic                       emit_free;
    logic                       fire;
    logic                       frame_good;

    assign req.ready = emit_free;
    assign fire      = req.valid && req.ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= mbrtu_pkg::SLAVE_ADDRESS_RESET;
            max_attempts_reg  <= mbrtu_pkg::MAX_ATTEMPTS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                mbrtu_pkg::CFG_SLAVE_ADDRESS: slave_address_reg <= wr_data[7:0];
                mbrtu_pkg::CFG_MAX_ATTEMPTS:  max_attempts_reg  <= wr_data[2:0];
            endcase
        end
    end

    assign frame_good = header_good_reg
                     && (running_crc_reg == {req.rx_byte, crc_low_hold_reg});

    // Decode the accepted item, update state and issue results
    always_comb
    begin
        logic clear;
        logic retry;

        busy_next          = busy_reg;
        attempt_count_next = attempt_count_reg;
        rx_count_next      = rx_count_reg;
        latched_next       = latched_reg;
        running_crc_next   = running_crc_reg;
        header_good_next   = header_good_reg;
        value_hold_next    = value_hold_reg;
        crc_low_hold_next  = crc_low_hold_reg;

        cmd.load             = 1'b0;
        cmd.finish           = 1'b0;
        cmd.success          = 1'b0;
        cmd.value            = value_hold_reg;
        cmd.slave            = slave_address_reg;
        cmd.register_address = latched_reg;

        clear = 1'b0;
        retry = 1'b0;

        if (fire)
        begin
            unique case (req.operation)
                mbrtu_pkg::OP_START:
                begin
                    if (!busy_reg)
                    begin
                        busy_next            = 1'b1;
                        latched_next         = req.register_address;
                        attempt_count_next   = 3'd1;
                        cmd.load             = 1'b1;
                        cmd.register_address = req.register_address;
                        clear                = 1'b1;
                    end
                end
                mbrtu_pkg::OP_TIMEOUT:
                begin
                    retry = busy_reg;
                end
                mbrtu_pkg::OP_RX_BYTE:
                begin
                    if (busy_reg)
                    begin
                        // Check header bytes and collect value and CRC
                        unique case (rx_count_reg)
                            mbrtu_pkg::RX_POS_ADDR:
                                if (req.rx_byte != slave_address_reg)
                                    header_good_next = 1'b0;
                            mbrtu_pkg::RX_POS_FUNC:
                                if (req.rx_byte != mbrtu_pkg::FUNC_READ_HOLDING)
                                    header_good_next = 1'b0;
                            mbrtu_pkg::RX_POS_COUNT:
                                if (req.rx_byte != mbrtu_pkg::BYTE_COUNT_ONE_REG)
                                    header_good_next = 1'b0;
                            mbrtu_pkg::RX_POS_VAL_HI:
                                value_hold_next = {req.rx_byte, 8'h00};
                            mbrtu_pkg::RX_POS_VAL_LO:
                                value_hold_next = {value_hold_reg[15:8], req.rx_byte};
                            mbrtu_pkg::RX_POS_CRC_LO:
                                crc_low_hold_next = req.rx_byte;
                            default:
                                ;
                        endcase
                        if (rx_count_reg < mbrtu_pkg::RX_POS_CRC_LO)
                        begin
                            running_crc_next = mbrtu_pkg::crc_byte(running_crc_reg, req.rx_byte);
                        end
                        if (rx_count_reg < mbrtu_pkg::RX_POS_CRC_HI)
                        begin
                            rx_count_next = rx_count_reg + 3'd1;
                        end
                        else if (frame_good)
                        begin
                            busy_next   = 1'b0;
                            clear       = 1'b1;
                            cmd.load    = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.success = 1'b1;
                        end
                        else
                        begin
                            retry = 1'b1;
                        end
                    end
                end
                default:
                    ;
            endcase

            // Resend the request or give up
            if (retry)
            begin
                clear    = 1'b1;
                cmd.load = 1'b1;
                if (attempt_count_reg < max_attempts_reg)
                begin
                    attempt_count_next = attempt_count_reg + 3'd1;
                end
                else
                begin
                    busy_next  = 1'b0;
                    cmd.finish = 1'b1;
                end
            end

            // Drop the partial response
            if (clear)
            begin
                rx_count_next     = mbrtu_pkg::RX_POS_ADDR;
                running_crc_next  = mbrtu_pkg::CRC_INIT;
                header_good_next  = 1'b1;
                value_hold_next   = 16'h0000;
                crc_low_hold_next = 8'h00;
            end
        end
    end

    // Hold transaction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            attempt_count_reg <= 3'd0;
            rx_count_reg      <= mbrtu_pkg::RX_POS_ADDR;
            latched_reg       <= 16'h0000;
            running_crc_reg   <= mbrtu_pkg::CRC_INIT;
            header_good_reg   <= 1'b1;
            value_hold_reg    <= 16'h0000;
            crc_low_hold_reg  <= 8'h00;
        end
        else
        begin
            busy_reg          <= busy_next;
            attempt_count_reg <= attempt_count_next;
            rx_count_reg      <= rx_count_next;
            latched_reg       <= latched_next;
            running_crc_reg   <= running_crc_next;
            header_good_reg   <= header_good_next;
            value_hold_reg    <= value_hold_next;
            crc_low_hold_reg  <= crc_low_hold_next;
        end
    end

    mbrtu_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .free  (emit_free),
        .rsp   (rsp)
    );

    // Checks
    `ASSERT_NEXT(a_start_sets_busy,
        fire && (req.operation == mbrtu_pkg::OP_START) && !busy_reg,
        busy_reg && rsp.valid && (rsp.kind == mbrtu_pkg::KIND_TX),
        "start from idle did not begin a request")
    `ASSERT_IMPL(a_finish_when_idle,
        rsp.valid && (rsp.kind == mbrtu_pkg::KIND_DONE), !busy_reg,
        "finish result shown while a transaction is open")
    `ASSERT_IMPL(a_busy_has_attempt, busy_reg, attempt_count_reg != 3'd0,
        "open transaction without a counted attempt")
    `ASSERT_CLK(a_rx_count_range, rx_count_reg != 3'd7,
        "response byte counter out of range")

endmodule
